FILE: hw/rtl/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
package pse_pkg;

    // ASCII codes recognized in the symbol stream
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    // Result status codes
    localparam logic [2:0] STS_OK    = 3'd0;
    localparam logic [2:0] STS_UNDER = 3'd1;
    localparam logic [2:0] STS_OVER  = 3'd2;
    localparam logic [2:0] STS_BADOP = 3'd3;
    localparam logic [2:0] STS_DIVZ  = 3'd4;

    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_SPACE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_POW,
        OP_BAD
    } op_t;

    typedef enum logic [1:0] {
        MUL_LR,
        MUL_SQ,
        MUL_BASE
    } mul_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_DIGIT,
        S_POP_R,
        S_POP_L,
        S_LOAD_L,
        S_ALU,
        S_MUL_P,
        S_MUL_F,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_FIX,
        S_POW_INIT,
        S_POW_SQ_P,
        S_POW_SQ_F,
        S_POW_MB_P,
        S_POW_MB_F,
        S_PUSH_RES,
        S_FINISH,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     push;
        logic     push_digit;
        logic     pop;
        logic     load_rhs;
        logic     load_lhs;
        logic     alu;
        logic     mul;
        mul_sel_t mul_sel;
        logic     mul_fix;
        logic     div_init;
        logic     div_step;
        logic     div_fix;
        logic     pow_init;
        logic     pow_next;
        logic     read_top;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic last;
        logic rhs_zero;
        logic pow_trivial;
        logic div_last;
        logic exp_msb;
        logic bit_last;
        logic out_free;
    } stat_t;

endpackage

FILE: hw/rtl/postfix_stack_evaluator.sv
// Postfix expression evaluator: top level joining controller and datapath.
//
// Input channel (s_): one ASCII character per transaction; s_tlast marks the
// last character of an expression. Digits push their value in signed fixed
// point with FRAC_BITS fraction bits, a space is skipped, any other character
// pops two operands and pushes the saturated result of + - * / ^, else zero.
// Output channel (m_): one transaction per expression, sent after the
// character marked last: the top of stack and the first error code seen.
// Division runs a restoring divider that retires one quotient bit per cycle
// and is skipped for a zero divisor; ^ runs square-and-multiply over 32
// exponent bits on one shared 32x32 multiplier and is skipped for a power
// whose exponent is below one. Reset clears the stack pointer, status and
// output valid; the stack memory itself is not cleared. A stalled receiver
// holds the result in the output register; the next expression runs and
// waits only at its own end.
module postfix_stack_evaluator
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] symbol
    input  logic        s_tlast,   // end_of_expression
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] value, [34:32] status, [39:35] zero
);

    cmd_t        cmd;
    stat_t       stat;
    logic [31:0] out_value;
    logic [2:0]  out_status;

    pse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_symbol  (s_tdata),
        .in_last    (s_tlast),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_value  (out_value),
        .out_status (out_status)
    );

    assign m_tdata = {5'd0, out_status, out_value};

endmodule

FILE: hw/rtl/pse_ctrl.sv
// Sequencing state machine for the postfix stack evaluator.
module pse_ctrl
    import pse_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                case (stat.op)
                    OP_DIGIT: state_next = S_PUSH_DIGIT;
                    OP_SPACE: state_next = S_FINISH;
                    default:  state_next = S_POP_R;
                endcase
            end
            S_PUSH_DIGIT: state_next = S_FINISH;
            S_POP_R:      state_next = S_POP_L;
            S_POP_L:      state_next = S_LOAD_L;
            S_LOAD_L: begin
                case (stat.op)
                    OP_MUL:  state_next = S_MUL_P;
                    OP_DIV:  state_next = S_DIV_INIT;
                    OP_POW:  state_next = S_POW_INIT;
                    default: state_next = S_ALU;
                endcase
            end
            S_ALU:   state_next = S_PUSH_RES;
            S_MUL_P: state_next = S_MUL_F;
            S_MUL_F: state_next = S_PUSH_RES;
            S_DIV_INIT: begin
                state_next = stat.rhs_zero ? S_PUSH_RES : S_DIV_RUN;
            end
            S_DIV_RUN: begin
                if (stat.div_last) state_next = S_DIV_FIX;
            end
            S_DIV_FIX: state_next = S_PUSH_RES;
            S_POW_INIT: begin
                state_next = stat.pow_trivial ? S_PUSH_RES : S_POW_SQ_P;
            end
            S_POW_SQ_P: state_next = S_POW_SQ_F;
            S_POW_SQ_F: begin
                if (stat.exp_msb) begin
                    state_next = S_POW_MB_P;
                end else begin
                    state_next = stat.bit_last ? S_PUSH_RES : S_POW_SQ_P;
                end
            end
            S_POW_MB_P: state_next = S_POW_MB_F;
            S_POW_MB_F: begin
                state_next = stat.bit_last ? S_PUSH_RES : S_POW_SQ_P;
            end
            S_PUSH_RES: state_next = S_FINISH;
            S_FINISH: begin
                state_next = stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.mul_sel = MUL_LR;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_DECODE: ;
            S_PUSH_DIGIT: begin
                cmd.push       = 1'b1;
                cmd.push_digit = 1'b1;
            end
            S_POP_R: cmd.pop = 1'b1;
            S_POP_L: begin
                cmd.load_rhs = 1'b1;
                cmd.pop      = 1'b1;
            end
            S_LOAD_L: cmd.load_lhs = 1'b1;
            S_ALU:    cmd.alu      = 1'b1;
            S_MUL_P: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_LR;
            end
            S_MUL_F:    cmd.mul_fix  = 1'b1;
            S_DIV_INIT: cmd.div_init = 1'b1;
            S_DIV_RUN:  cmd.div_step = 1'b1;
            S_DIV_FIX:  cmd.div_fix  = 1'b1;
            S_POW_INIT: cmd.pow_init = 1'b1;
            S_POW_SQ_P: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_SQ;
            end
            S_POW_SQ_F: begin
                cmd.mul_fix  = 1'b1;
                // advance to the next exponent bit unless a base multiply follows
                cmd.pow_next = !stat.exp_msb;
            end
            S_POW_MB_P: begin
                cmd.mul     = 1'b1;
                cmd.mul_sel = MUL_BASE;
            end
            S_POW_MB_F: begin
                cmd.mul_fix  = 1'b1;
                cmd.pow_next = 1'b1;
            end
            S_PUSH_RES: cmd.push = 1'b1;
            S_FINISH:   cmd.read_top = stat.last;
            S_EMIT:     cmd.emit = stat.out_free;
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/pse_datapath.sv
// Operand stack, arithmetic units and result register for the postfix evaluator.
module pse_datapath
    import pse_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [7:0]  in_symbol,
    input  logic        in_last,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] out_value,
    output logic [2:0]  out_status
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 1);
    localparam logic [31:0] ONE       = 32'(64'd1 << FRAC_BITS);
    localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic [31:0] MAXV      = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV      = 32'h8000_0000;

    // operand stack
    logic [31:0]    stack_mem [STACK_DEPTH];
    logic [31:0]    rd_data_reg;
    logic           pop_zero_reg;
    logic [SPW-1:0] sp_reg;
    logic [SPW-1:0] sp_next;
    logic [SPW-1:0] sp_dec;
    logic           sp_empty;
    logic           sp_full;
    logic           wr_en;
    logic [31:0]    wr_data;
    logic           rd_en;

    logic [2:0]     status_reg;
    logic [2:0]     status_next;
    logic           note_en;
    logic [2:0]     note_code;

    logic [7:0]     sym_reg;
    logic           last_reg;
    op_t            op;

    logic [31:0]    pop_value;
    logic [31:0]    digit_value;
    logic signed [31:0] rhs_reg;
    logic signed [31:0] lhs_reg;
    logic signed [31:0] acc_reg;

    // add / subtract
    logic signed [32:0] sum_wide;
    logic [31:0]        sum_sat;

    // multiply
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod_full;
    logic signed [63:0] prod_reg;
    logic signed [63:0] fix_sum;
    logic signed [63:0] fix_shr;
    logic [31:0]        fix_sat;

    // divide
    logic [NUM_W-1:0] num_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      den_reg;
    logic             neg_reg;
    logic [CW-1:0]    div_cnt_reg;
    logic [32:0]      rem_shift;
    logic             rem_ge;
    logic [31:0]      mag_a;
    logic [31:0]      mag_b;
    logic [31:0]      divz_value;
    logic [31:0]      div_sat;

    // power
    logic [31:0] exp_reg;
    logic [4:0]  bit_cnt_reg;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [2:0]  out_status_reg;

    always_comb begin
        if (sym_reg >= CH_ZERO && sym_reg <= CH_NINE) begin
            op = OP_DIGIT;
        end else begin
            unique case (sym_reg)
                CH_SPACE: op = OP_SPACE;
                CH_PLUS:  op = OP_ADD;
                CH_MINUS: op = OP_SUB;
                CH_STAR:  op = OP_MUL;
                CH_SLASH: op = OP_DIV;
                CH_CARET: op = OP_POW;
                default:  op = OP_BAD;
            endcase
        end
    end

    assign sp_dec      = sp_reg - 1'b1;
    assign sp_empty    = (sp_reg == '0);
    assign sp_full     = (sp_reg == SPW'(STACK_DEPTH));
    assign pop_value   = pop_zero_reg ? 32'd0 : rd_data_reg;
    assign digit_value = 32'(sym_reg - CH_ZERO) << FRAC_BITS;
    assign wr_data     = cmd.push_digit ? digit_value : acc_reg;

    // stack pointer and first-error status
    always_comb begin
        sp_next   = sp_reg;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        note_en   = 1'b0;
        note_code = STS_OK;
        if (cmd.pop) begin
            if (sp_empty) begin
                note_en   = 1'b1;
                note_code = STS_UNDER;
            end else begin
                rd_en   = 1'b1;
                sp_next = sp_dec;
            end
        end
        if (cmd.read_top && !sp_empty) rd_en = 1'b1;
        if (cmd.push) begin
            if (sp_full) begin
                note_en   = 1'b1;
                note_code = STS_OVER;
            end else begin
                wr_en   = 1'b1;
                sp_next = sp_reg + 1'b1;
            end
        end
        if (cmd.alu && op == OP_BAD) begin
            note_en   = 1'b1;
            note_code = STS_BADOP;
        end
        if (cmd.div_init && rhs_reg == 32'sd0) begin
            note_en   = 1'b1;
            note_code = STS_DIVZ;
        end
        status_next = status_reg;
        if (note_en && status_reg == STS_OK) status_next = note_code;
        if (cmd.emit) begin
            sp_next     = '0;
            status_next = STS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) stack_mem[sp_reg[AW-1:0]] <= wr_data;
        if (rd_en) rd_data_reg <= stack_mem[sp_dec[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg        <= '0;
            status_reg    <= STS_OK;
            out_valid_reg <= 1'b0;
        end else begin
            sp_reg     <= sp_next;
            status_reg <= status_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // add / subtract with saturation
    always_comb begin
        if (op == OP_SUB) begin
            sum_wide = {lhs_reg[31], lhs_reg} - {rhs_reg[31], rhs_reg};
        end else begin
            sum_wide = {lhs_reg[31], lhs_reg} + {rhs_reg[31], rhs_reg};
        end
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? MINV : MAXV;
        end else begin
            sum_sat = sum_wide[31:0];
        end
    end

    // multiplier operand select
    always_comb begin
        case (cmd.mul_sel)
            MUL_SQ: begin
                mul_a = acc_reg;
                mul_b = acc_reg;
            end
            MUL_BASE: begin
                mul_a = acc_reg;
                mul_b = lhs_reg;
            end
            default: begin
                mul_a = lhs_reg;
                mul_b = rhs_reg;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // drop fraction bits with truncation toward zero, then saturate
    always_comb begin
        fix_sum = prod_reg + $signed(prod_reg[63] ? FRAC_MASK : 64'd0);
        fix_shr = fix_sum >>> FRAC_BITS;
        if (fix_shr > 64'sd2147483647) begin
            fix_sat = MAXV;
        end else if (fix_shr < -64'sd2147483648) begin
            fix_sat = MINV;
        end else begin
            fix_sat = fix_shr[31:0];
        end
    end

    // restoring divider on magnitudes
    assign mag_a     = lhs_reg[31] ? 32'd0 - lhs_reg : lhs_reg;
    assign mag_b     = rhs_reg[31] ? 32'd0 - rhs_reg : rhs_reg;
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    always_comb begin
        if (lhs_reg > 32'sd0) begin
            divz_value = MAXV;
        end else if (lhs_reg < 32'sd0) begin
            divz_value = MINV;
        end else begin
            divz_value = 32'd0;
        end
        if (!neg_reg) begin
            div_sat = (num_reg > NUM_W'(MAXV)) ? MAXV : num_reg[31:0];
        end else begin
            div_sat = (num_reg > NUM_W'(MINV)) ? MINV : 32'd0 - num_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sym_reg  <= in_symbol;
            last_reg <= in_last;
        end
        if (cmd.pop || cmd.read_top) pop_zero_reg <= sp_empty;
        if (cmd.load_rhs) rhs_reg <= pop_value;
        if (cmd.load_lhs) lhs_reg <= pop_value;
        if (cmd.mul) prod_reg <= prod_full;

        if (cmd.alu) acc_reg <= (op == OP_BAD) ? 32'sd0 : sum_sat;
        if (cmd.mul_fix) acc_reg <= fix_sat;
        if (cmd.div_fix) acc_reg <= div_sat;

        if (cmd.div_init) begin
            if (rhs_reg == 32'sd0) acc_reg <= divz_value;
            num_reg     <= NUM_W'(mag_a) << FRAC_BITS;
            rem_reg     <= 32'd0;
            den_reg     <= mag_b;
            neg_reg     <= lhs_reg[31] ^ rhs_reg[31];
            div_cnt_reg <= CW'(NUM_W);
        end
        if (cmd.div_step) begin
            rem_reg     <= rem_ge ? 32'(rem_shift - {1'b0, den_reg}) : rem_shift[31:0];
            num_reg     <= {num_reg[NUM_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end

        if (cmd.pow_init) begin
            acc_reg     <= ONE;
            exp_reg     <= 32'(rhs_reg >>> FRAC_BITS);
            bit_cnt_reg <= 5'd31;
        end
        if (cmd.pow_next) begin
            exp_reg     <= {exp_reg[30:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end

        if (cmd.emit) begin
            out_value_reg  <= pop_value;
            // empty stack at the end mark reports underflow unless an error is held
            out_status_reg <= (status_reg == STS_OK && pop_zero_reg) ? STS_UNDER : status_reg;
        end
    end

    assign stat.op          = op;
    assign stat.last        = last_reg;
    assign stat.rhs_zero    = (rhs_reg == 32'sd0);
    assign stat.pow_trivial = (rhs_reg < $signed(ONE));
    assign stat.div_last    = (div_cnt_reg == CW'(1));
    assign stat.exp_msb     = exp_reg[31];
    assign stat.bit_last    = (bit_cnt_reg == 5'd0);
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

FILE: test/postfix_stack_evaluator_tb.sv
// Self-checking testbench for the postfix stack evaluator.
`timescale 1ns / 1ps

module postfix_stack_evaluator_tb
    import pse_pkg::*;
();

    localparam int     DEPTH       = 16;
    localparam int     FRAC        = 16;
    localparam longint UNIT        = longint'(1) << FRAC;
    localparam longint Q_MAX       = 64'sd2147483647;
    localparam longint Q_MIN       = -64'sd2147483647 - 64'sd1;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     TAIL_CYCLES = 160;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  status;
    } outcome_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] symbol
    logic        s_tlast  = 1'b0;    // end_of_expression
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [31:0] value, [34:32] status, [39:35] zero

    // evaluator state mirrored on the accepted symbol stream
    int          eval_stack [DEPTH];
    int unsigned eval_depth  = 0;
    logic [2:0]  eval_status = STS_OK;
    outcome_t    expected_results [$];

    int  mismatches   = 0;
    int  symbols_sent = 0;
    int  cycle_count  = 0;
    int  sink_hold    = 0;
    int  sink_wait    = 0;
    bit  calm_source  = 1'b0;
    bit  calm_sink    = 1'b0;

    postfix_stack_evaluator #(
        .STACK_DEPTH(DEPTH),
        .FRAC_BITS  (FRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void note_error(logic [2:0] code);
        if (eval_status == STS_OK)
            eval_status = code;
    endfunction

    function automatic int saturate(longint x);
        if (x > Q_MAX)
            return int'(Q_MAX);
        if (x < Q_MIN)
            return int'(Q_MIN);
        return int'(x);
    endfunction

    function automatic int fixed_mul(int a, int b);
        longint product;
        product = longint'(a) * longint'(b);
        return saturate(product / UNIT);
    endfunction

    function automatic int fixed_div(int a, int b);
        if (b == 0) begin
            note_error(STS_DIVZ);
            if (a > 0)
                return int'(Q_MAX);
            if (a < 0)
                return int'(Q_MIN);
            return 0;
        end
        return saturate((longint'(a) * UNIT) / longint'(b));
    endfunction

    // square-and-multiply over the integer part of the exponent, msb first
    function automatic int fixed_pow(int base, int ex);
        longint whole;
        int     acc;
        whole = longint'(ex) / UNIT;
        acc   = int'(UNIT);
        if (whole <= 0)
            return acc;
        for (int k = 31; k >= 0; k--) begin
            acc = fixed_mul(acc, acc);
            if (whole[k])
                acc = fixed_mul(acc, base);
        end
        return acc;
    endfunction

    function automatic void stack_push(int v);
        if (eval_depth < DEPTH) begin
            eval_stack[eval_depth] = v;
            eval_depth++;
        end else begin
            note_error(STS_OVER);
        end
    endfunction

    function automatic int stack_pop();
        if (eval_depth == 0) begin
            note_error(STS_UNDER);
            return 0;
        end
        eval_depth--;
        return eval_stack[eval_depth];
    endfunction

    function automatic int combine(int lhs, int rhs, logic [7:0] op);
        case (op)
            CH_PLUS:  return saturate(longint'(lhs) + longint'(rhs));
            CH_MINUS: return saturate(longint'(lhs) - longint'(rhs));
            CH_STAR:  return fixed_mul(lhs, rhs);
            CH_SLASH: return fixed_div(lhs, rhs);
            CH_CARET: return fixed_pow(lhs, rhs);
            default: begin
                note_error(STS_BADOP);
                return 0;
            end
        endcase
    endfunction

    function automatic void evaluate_symbol(logic [7:0] sym, logic last);
        int       rhs;
        int       lhs;
        outcome_t res;
        if (sym >= CH_ZERO && sym <= CH_NINE) begin
            stack_push(int'(sym - CH_ZERO) * int'(UNIT));
        end else if (sym != CH_SPACE) begin
            rhs = stack_pop();
            lhs = stack_pop();
            stack_push(combine(lhs, rhs, sym));
        end
        if (last) begin
            res.value = '0;
            if (eval_depth == 0)
                note_error(STS_UNDER);
            else
                res.value = eval_stack[eval_depth - 1];
            res.status = eval_status;
            expected_results.push_back(res);
            eval_depth  = 0;
            eval_status = STS_OK;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            evaluate_symbol(s_tdata, s_tlast);
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual value %h status %0d",
                         $time, m_tdata[31:0], m_tdata[34:32]);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    mismatches++;
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, want.value, m_tdata[31:0]);
                end
                if (m_tdata[34:32] !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tdata[34:32]);
                end
            end
        end
    end

    // result sink: random stalls after each transaction, long hold on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else if (sink_hold > 0) begin
            m_tready <= 1'b0;
            sink_hold--;
        end else if (m_tvalid && m_tready) begin
            sink_wait = calm_sink ? 0 : $urandom_range(0, 7);
            m_tready <= (sink_wait == 0);
        end else if (!m_tready) begin
            if (sink_wait > 0)
                sink_wait--;
            if (sink_wait == 0)
                m_tready <= 1'b1;
        end
    end

    task automatic send_symbol(input logic [7:0] sym, input logic last);
        int gap;
        gap = calm_source ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        symbols_sent++;
    endtask

    task automatic send_expression(input string text);
        for (int k = 0; k < text.len(); k++)
            send_symbol(text[k], k == text.len() - 1);
    endtask

    // hold the source until every pending result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_operator();
        int         roll;
        logic [7:0] junk;
        roll = $urandom_range(0, 19);
        if (roll < 5)
            return CH_PLUS;
        if (roll < 9)
            return CH_MINUS;
        if (roll < 13)
            return CH_STAR;
        if (roll < 17)
            return CH_SLASH;
        if (roll < 19)
            return CH_CARET;
        do
            junk = 8'($urandom_range(0, 255));
        while (junk inside {[CH_ZERO:CH_NINE], CH_SPACE, CH_PLUS, CH_MINUS,
                            CH_STAR, CH_SLASH, CH_CARET});
        return junk;
    endfunction

    // mostly well-formed expressions; some noise, some left unbalanced, some deep
    task automatic send_random_expression();
        logic [7:0] chars [$];
        int         style;
        int         length;
        int         depth;
        int         push_weight;
        style       = $urandom_range(0, 9);
        length      = $urandom_range(1, 20);
        depth       = 0;
        push_weight = (style == 2) ? 9 : 4;
        if (style == 0) begin
            repeat (length) chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (int k = 0; k < length; k++) begin
                if ($urandom_range(0, 7) == 0)
                    chars.push_back(CH_SPACE);
                if (depth < 2 || ($urandom_range(0, 9) < push_weight && depth < 20)) begin
                    chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    depth++;
                end else begin
                    chars.push_back(pick_operator());
                    depth--;
                end
            end
            if (style > 1) begin
                while (depth > 1) begin
                    chars.push_back(pick_operator());
                    depth--;
                end
            end
        end
        foreach (chars[k])
            send_symbol(chars[k], k == chars.size() - 1);
    endtask

    task automatic test_arithmetic();
        send_expression("34+");
        send_expression("35-");
        send_expression("34*");
        send_expression("17/");
        send_expression("23^");
        send_expression("21^");
        send_expression("20^");
        send_expression("203-^");
        send_expression("9 9*");
        drain_results();
    endtask

    task automatic test_error_codes();
        send_expression("90/");
        send_expression("00/");
        send_expression("09-0/");
        send_expression("+");
        send_expression(" ");
        send_symbol(CH_ZERO + 8'd1, 1'b0);
        send_symbol(CH_ZERO + 8'd2, 1'b0);
        send_symbol(8'hFF, 1'b1);
        send_symbol(CH_ZERO + 8'd9, 1'b0);
        send_symbol(8'h00, 1'b1);
        send_expression("99^9^");
        send_expression("09-9^");
        send_expression("+0/");
        drain_results();
    endtask

    task automatic test_stack_limits();
        repeat (DEPTH) send_symbol(CH_ZERO + 8'd9, 1'b0);
        for (int k = 1; k < DEPTH; k++)
            send_symbol(CH_PLUS, k == DEPTH - 1);
        repeat (DEPTH) send_symbol(CH_ZERO + 8'd1, 1'b0);
        send_symbol(CH_ZERO + 8'd2, 1'b1);
        send_expression("123");
        drain_results();
    endtask

    // keep the sink stalled so the block fills its output and stalls the source
    task automatic test_output_backpressure();
        sink_hold = 2000;
        repeat (4) send_expression("12+");
        repeat (8) send_random_expression();
        drain_results();
    endtask

    task automatic test_random_expressions();
        int target;
        target = symbols_sent + 550;
        while (symbols_sent < target) begin
            if ($urandom_range(0, 19) == 0)
                calm_source = !calm_source;
            if ($urandom_range(0, 19) == 0)
                calm_sink = !calm_sink;
            if ($urandom_range(0, 29) == 0)
                drain_results();
            send_random_expression();
        end
        calm_source = 1'b0;
        calm_sink   = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_arithmetic();
        test_error_codes();
        test_stack_limits();
        test_output_backpressure();
        test_random_expressions();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
